>>> design/dma2_pkg.sv
// shared types and constants for the two-channel dma controller
package dma2_pkg;

	localparam int WORD_BYTES_DEF = 4;
	localparam int Q_DEPTH        = 4;
	localparam int Q_PTR_W        = $clog2(Q_DEPTH);
	localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_RDATA = 2'd2;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	localparam logic [1:0] REG_SOURCE = 2'd0;
	localparam logic [1:0] REG_TARGET = 2'd1;
	localparam logic [1:0] REG_SIZE   = 2'd2;
	localparam logic [1:0] REG_START  = 2'd3;

	localparam logic [1:0] WAIT_IDLE = 2'd0;
	localparam logic [1:0] WAIT_CH0  = 2'd1;
	localparam logic [1:0] WAIT_CH1  = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic        req_channel;
		logic [31:0] address;
		logic [31:0] wdata;
		logic        irq_first;
		logic        irq_second;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0] wait_phase;
		logic       second_pending;
	} eng_status_t;

endpackage

>>> design/dma2_engine.sv
// channel state and per-request processing of the dma controller
module dma2_engine #(
	parameter int WordBytes = dma2_pkg::WORD_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [1:0]            command,
	input  logic                  channel,
	input  logic [1:0]            reg_index,
	input  logic [31:0]           value,
	output dma2_pkg::result_t     res0,
	output dma2_pkg::result_t     res1,
	output logic [1:0]            res_n,
	output dma2_pkg::eng_status_t status
);
	import dma2_pkg::*;

	localparam logic [31:0] STEP = 32'(WordBytes);

	logic [31:0] shadow_q [8];
	logic [31:0] src_q [2];
	logic [31:0] tgt_q [2];
	logic [31:0] size_q [2];
	logic [31:0] off_q [2];
	logic [1:0]  started_q;
	logic [1:0]  irq_q;
	logic [1:0]  wait_q;
	logic        pend_q;

	logic [31:0] src_d [2];
	logic [31:0] tgt_d [2];
	logic [31:0] size_d [2];
	logic [31:0] off_d [2];
	logic [1:0]  started_d;
	logic [1:0]  irq_d;
	logic [1:0]  wait_d;
	logic        pend_d;

	logic [1:0]  finished;
	logic [1:0]  can_read;
	logic [1:0]  start_sh;
	logic [1:0]  serve_en;
	logic        waiting;
	logic        rd_ch;
	logic        wr_en;

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			finished[c] = off_q[c] >= size_q[c];
			can_read[c] = started_q[c] && !finished[c];
			start_sh[c] = shadow_q[{1'(c), REG_START}] != 32'd0;
		end
	end

	assign waiting = (wait_q == WAIT_CH0) || (wait_q == WAIT_CH1);
	assign rd_ch   = (wait_q == WAIT_CH1);
	assign wr_en   = fire && (command == CMD_WRITE)
		&& (!started_q[channel] || finished[channel]);

	always_comb begin
		src_d     = src_q;
		tgt_d     = tgt_q;
		size_d    = size_q;
		off_d     = off_q;
		started_d = started_q;
		irq_d     = irq_q;
		wait_d    = wait_q;
		pend_d    = pend_q;
		serve_en  = 2'b00;
		res0      = '0;
		res1      = '0;
		res_n     = 2'd1;

		if (fire) begin
			case (command)
				CMD_TICK: begin
					if (!waiting) begin
						wait_d      = WAIT_IDLE;
						serve_en[0] = 1'b1;
						serve_en[1] = !can_read[0];
						if (can_read[0]) begin
							res0.kind    = KIND_READ;
							res0.address = src_q[0] + off_q[0];
							wait_d       = WAIT_CH0;
							pend_d       = 1'b1;
						end else if (can_read[1]) begin
							res0.kind        = KIND_READ;
							res0.req_channel = 1'b1;
							res0.address     = src_q[1] + off_q[1];
							wait_d           = WAIT_CH1;
						end
					end
				end
				CMD_RDATA: begin
					if (waiting) begin
						res0.kind        = KIND_WRITE;
						res0.req_channel = rd_ch;
						res0.address     = tgt_q[rd_ch] + off_q[rd_ch];
						res0.wdata       = value;
						off_d[rd_ch]     = off_q[rd_ch] + STEP;
						wait_d           = WAIT_IDLE;
						// channel 1 still owed its turn from the suspended tick
						if (pend_q) begin
							pend_d      = 1'b0;
							serve_en[1] = 1'b1;
							if (can_read[1]) begin
								res1.kind        = KIND_READ;
								res1.req_channel = 1'b1;
								res1.address     = src_q[1] + off_q[1];
								res_n            = 2'd2;
								wait_d           = WAIT_CH1;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end

		for (int c = 0; c < 2; c++) begin
			if (serve_en[c]) begin
				if (!started_q[c]) begin
					src_d[c]     = shadow_q[{1'(c), REG_SOURCE}];
					tgt_d[c]     = shadow_q[{1'(c), REG_TARGET}];
					size_d[c]    = shadow_q[{1'(c), REG_SIZE}];
					started_d[c] = start_sh[c];
					irq_d[c]     = 1'b0;
					off_d[c]     = 32'd0;
				end else if (finished[c]) begin
					irq_d[c]     = 1'b1;
					started_d[c] = start_sh[c];
				end
			end
		end

		res0.irq_first  = irq_d[0];
		res0.irq_second = irq_d[1];
		res0.last       = (res_n == 2'd1);
		res1.irq_first  = irq_d[0];
		res1.irq_second = irq_d[1];
		res1.last       = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				shadow_q[i] <= 32'd0;
			end
			for (int c = 0; c < 2; c++) begin
				src_q[c]  <= 32'd0;
				tgt_q[c]  <= 32'd0;
				size_q[c] <= 32'd0;
				off_q[c]  <= 32'd0;
			end
			started_q <= 2'b00;
			irq_q     <= 2'b00;
			wait_q    <= WAIT_IDLE;
			pend_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				shadow_q[{channel, reg_index}] <= value;
			end
			src_q     <= src_d;
			tgt_q     <= tgt_d;
			size_q    <= size_d;
			off_q     <= off_d;
			started_q <= started_d;
			irq_q     <= irq_d;
			wait_q    <= wait_d;
			pend_q    <= pend_d;
		end
	end

	assign status.wait_phase     = wait_q;
	assign status.second_pending = pend_q;

endmodule

>>> design/dma2_res_queue.sv
// small result queue taking up to two results per cycle
module dma2_res_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [1:0]                   push_n,
	input  dma2_pkg::result_t            din0,
	input  dma2_pkg::result_t            din1,
	input  logic                         pop,
	output dma2_pkg::result_t            head,
	output logic [dma2_pkg::Q_CNT_W-1:0] count
);
	import dma2_pkg::*;

	result_t              mem [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wp_q;
	logic [Q_PTR_W-1:0]   rp_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 do_pop;

	assign do_pop = pop && (cnt_q != '0);
	assign head   = mem[rp_q];
	assign count  = cnt_q;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wp_q] <= din0;
		end
		if (push_n == 2'd2) begin
			mem[wp_q + Q_PTR_W'(1)] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + Q_PTR_W'(push_n);
			rp_q  <= rp_q + Q_PTR_W'(do_pop);
			cnt_q <= cnt_q + Q_CNT_W'(push_n) - Q_CNT_W'(do_pop);
		end
	end

endmodule

>>> design/two_channel_dma_controller.sv
// two-channel word-copy dma controller, top level
//
// requests arrive on cmd_valid/cmd_ready with command, channel, reg_index and
// value: a shadow register write, a tick, or read data coming back from memory.
// each request yields one or two results on res_valid/res_ready: a bus request
// (kind none, read or write) with channel, address and write data, both
// interrupt levels, and last on the final result of the request.
// a request is taken into an input register, processed against the channel state
// once the queue has room for two results, and pushed into a four-entry result
// queue; the first result then shows on the outputs at the queue head and is
// taken on a clock edge with res_ready high.
// one request per cycle is accepted while the queue has room for two more
// results; a request that yields two results fills two queue entries, so the
// sustained rate is one result per cycle at the output while res_ready is high.
// when the receiver stalls the queue fills and cmd_ready drops once fewer than
// two free entries remain; nothing is dropped.
// reset clears all shadow and active registers, interrupts, the pending read
// state, the input register and the queue.
module two_channel_dma_controller #(
	parameter int WordBytes = dma2_pkg::WORD_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [1:0]  command,
	input  logic        channel,
	input  logic [1:0]  reg_index,
	input  logic [31:0] value,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  kind,
	output logic        req_channel,
	output logic [31:0] address,
	output logic [31:0] wdata,
	output logic        irq_first,
	output logic        irq_second,
	output logic        last
);
	import dma2_pkg::*;

	logic               valid_s1;
	logic [1:0]         command_s1;
	logic               channel_s1;
	logic [1:0]         reg_index_s1;
	logic [31:0]        value_s1;
	logic               fire;
	result_t            res0;
	result_t            res1;
	result_t            head;
	logic [1:0]         res_n;
	logic [1:0]         push_n;
	logic [Q_CNT_W-1:0] count;
	eng_status_t        status;

	// room for two results keeps the worst case request safe
	assign fire      = valid_s1 && (count <= Q_CNT_W'(Q_DEPTH - 2));
	assign cmd_ready = !valid_s1 || fire;
	assign push_n    = fire ? res_n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			command_s1   <= command;
			channel_s1   <= channel;
			reg_index_s1 <= reg_index;
			value_s1     <= value;
		end
	end

	dma2_engine #(
		.WordBytes(WordBytes)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.command   (command_s1),
		.channel   (channel_s1),
		.reg_index (reg_index_s1),
		.value     (value_s1),
		.res0      (res0),
		.res1      (res1),
		.res_n     (res_n),
		.status    (status)
	);

	dma2_res_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (push_n),
		.din0   (res0),
		.din1   (res1),
		.pop    (res_ready),
		.head   (head),
		.count  (count)
	);

	assign res_valid   = count != '0;
	assign kind        = head.kind;
	assign req_channel = head.req_channel;
	assign address     = head.address;
	assign wdata       = head.wdata;
	assign irq_first   = head.irq_first;
	assign irq_second  = head.irq_second;
	assign last        = head.last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= Q_CNT_W'(Q_DEPTH))
		else $error("result queue overflow");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (res_n == 2'd1 || res_n == 2'd2))
		else $error("request produced no result");

	a_pending_ch0: assert property (@(posedge clk) disable iff (!arst_n)
		status.second_pending |-> status.wait_phase == WAIT_CH0)
		else $error("channel 1 pending without channel 0 read outstanding");

	a_two_needs_wait: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_n == 2'd2 |=> status.wait_phase == WAIT_CH1)
		else $error("second read result without channel 1 read outstanding");

endmodule
